// ===== rtl/core/timed_interrupt_line_queue_assert.svh =====
// ----------------------------------------------------------------------------
// timed_interrupt_line_queue_assert.svh
// assertion macros shared by the interrupt line queue
// ----------------------------------------------------------------------------
`ifndef TIMED_INTERRUPT_LINE_QUEUE_ASSERT_SVH
`define TIMED_INTERRUPT_LINE_QUEUE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define TILQ_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("tilq assertion failed");

// next-cycle implication, checked out of reset
`define TILQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("tilq assertion failed");

`endif

// ===== rtl/core/tilq_pkg.sv =====
// ----------------------------------------------------------------------------
// tilq_pkg
// shared types and constants of the timed interrupt line queue
// ----------------------------------------------------------------------------
`default_nettype none

package tilq_pkg;

  localparam int DEF_LINE_COUNT  = 64;
  localparam int DEF_QUEUE_DEPTH = 16;

  localparam int STAMP_W = 64;
  localparam int LINE_W  = 6;

  // command codes
  localparam logic CMD_QUEUE = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  // trigger modes
  localparam logic MODE_EDGE  = 1'b0;
  localparam logic MODE_LEVEL = 1'b1;

  // configuration register indexes
  localparam logic CFG_TRIGGER_MODE = 1'b0;
  localparam logic CFG_CLEAR_ON_LOW = 1'b1;

  typedef struct packed {
    logic [STAMP_W-1:0] stamp;
    logic [LINE_W-1:0]  line;
    logic               level;
  } tilq_entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_INS_SCAN,
    ST_INS_PUT,
    ST_TICK_RD,
    ST_TICK_EVAL,
    ST_DONE
  } tilq_state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_OVERFLOW,
    OP_PUT_FRONT,
    OP_SCAN_START,
    OP_SHIFT,
    OP_PLACE,
    OP_TICK_INIT,
    OP_TICK_READ,
    OP_TICK_APPLY,
    OP_PUBLISH
  } tilq_op_t;

  typedef struct packed {
    logic is_tick;
    logic full;
    logic empty;
    logic j_zero;
    logic later;
    logic due;
    logic stop;
    logic out_busy;
  } tilq_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/timed_interrupt_line_queue.sv =====
// ----------------------------------------------------------------------------
// timed_interrupt_line_queue
// time-sorted queue of interrupt line changes with tick-driven evaluation
// ----------------------------------------------------------------------------
// usage:
//   input words (in_valid / in_stall) either queue a line event (cmd 0) or run
//   a tick at in_now_time (cmd 1). every input word gives exactly one result
//   word on out_valid / out_stall, in order.
//   config registers are written through cfg_we / cfg_index / cfg_wdata only
//   while no word is in flight, a rule for the user that the block does not
//   enforce: index 0 trigger_mode, index 1 clear_on_low.
//   one word is worked on at a time; in_stall is high from acceptance until
//   the result is loaded into the output register.
//   queue, empty or full queue: capture, decode, then result handover.
//   queue, otherwise: each queued event with a later stamp is moved up one slot
//   per cycle, with one read and one write of the event memory, then the new
//   event is placed. tick: a memory read then an apply for each popped event,
//   until it stops on an applied event, the queue runs empty or one is not due.
// reset (rst_n low, synchronous): queue empty, line vector and raised mask
//   clear, level mode, clear_on_low off. event memory is not cleared.
// stall: a finished result waits in the output register; the next word is
//   accepted and worked on, and only its result handover waits for out_stall.
// ----------------------------------------------------------------------------
`default_nettype none

`include "timed_interrupt_line_queue_assert.svh"

module timed_interrupt_line_queue
  import tilq_pkg::*;
#(
  parameter int LINE_COUNT  = DEF_LINE_COUNT,
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // config port
  input  wire logic               cfg_we,
  input  wire logic [0:0]         cfg_index,
  input  wire logic [0:0]         cfg_wdata,
  // input channel
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_cmd,
  input  wire logic [LINE_W-1:0]  in_line,
  input  wire logic               in_level,
  input  wire logic [STAMP_W-1:0] in_event_time,
  input  wire logic [STAMP_W-1:0] in_now_time,
  input  wire logic               in_global_enable,
  // result channel
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    out_interrupt_request,
  output logic [63:0]             out_line_bits,
  output logic                    out_queue_overflow,
  output logic [4:0]              out_pending_left
);

  tilq_op_t     op;
  tilq_status_t status;

  // sequencer: one command per cycle to the datapath
  tilq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .status   (status),
    .op       (op),
    .busy     (in_stall)
  );

  // event ring, line state and result registers
  tilq_datapath #(
    .LINE_COUNT  (LINE_COUNT),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .op                    (op),
    .status                (status),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata),
    .in_cmd                (in_cmd),
    .in_line               (in_line),
    .in_level              (in_level),
    .in_event_time         (in_event_time),
    .in_now_time           (in_now_time),
    .in_global_enable      (in_global_enable),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_interrupt_request (out_interrupt_request),
    .out_line_bits         (out_line_bits),
    .out_queue_overflow    (out_queue_overflow),
    .out_pending_left      (out_pending_left)
  );

  // an accepted word keeps the block busy in the following cycle
  `TILQ_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)
  // an event is only applied when it is due and the queue holds something
  `TILQ_ASSERT_NOW(a_apply_when_due, clk, rst_n, op == OP_TICK_APPLY, status.due && !status.empty)
  // a dropped event never comes with an interrupt request
  `TILQ_ASSERT_NOW(a_ovf_no_irq, clk, rst_n, out_valid && out_queue_overflow, !out_interrupt_request)

endmodule

`default_nettype wire

// ===== rtl/core/tilq_ctrl.sv =====
// ----------------------------------------------------------------------------
// tilq_ctrl
// sequencer that steps the datapath through insert and tick operations
// ----------------------------------------------------------------------------
`default_nettype none

module tilq_ctrl
  import tilq_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  input  wire tilq_status_t status,
  output tilq_op_t          op,
  output logic              busy
);

  tilq_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_DECODE;
      end
      ST_DECODE: begin
        priority if (status.is_tick) state_nxt = ST_TICK_RD;
        else if (status.full || status.empty) state_nxt = ST_DONE;
        else state_nxt = ST_INS_SCAN;
      end
      ST_INS_SCAN: begin
        priority if (status.later && status.j_zero) state_nxt = ST_INS_PUT;
        else if (status.later) state_nxt = ST_INS_SCAN;
        else state_nxt = ST_DONE;
      end
      ST_INS_PUT: state_nxt = ST_DONE;
      ST_TICK_RD: begin
        state_nxt = status.empty ? ST_DONE : ST_TICK_EVAL;
      end
      ST_TICK_EVAL: begin
        state_nxt = (status.due && !status.stop) ? ST_TICK_RD : ST_DONE;
      end
      ST_DONE: begin
        if (!status.out_busy) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    op   = OP_NONE;
    busy = (state_r != ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) op = OP_CAPTURE;
      end
      ST_DECODE: begin
        priority if (status.is_tick) op = OP_TICK_INIT;
        else if (status.full) op = OP_OVERFLOW;
        else if (status.empty) op = OP_PUT_FRONT;
        else op = OP_SCAN_START;
      end
      ST_INS_SCAN: op = status.later ? OP_SHIFT : OP_PLACE;
      ST_INS_PUT:  op = OP_PUT_FRONT;
      ST_TICK_RD: begin
        if (!status.empty) op = OP_TICK_READ;
      end
      ST_TICK_EVAL: begin
        if (status.due) op = OP_TICK_APPLY;
      end
      ST_DONE: begin
        if (!status.out_busy) op = OP_PUBLISH;
      end
      default: op = OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/tilq_datapath.sv =====
// ----------------------------------------------------------------------------
// tilq_datapath
// pending-event memory as a ring, line state, config and result registers
// ----------------------------------------------------------------------------
`default_nettype none

module tilq_datapath
  import tilq_pkg::*;
#(
  parameter int LINE_COUNT  = DEF_LINE_COUNT,
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire tilq_op_t           op,
  output tilq_status_t            status,
  input  wire logic               cfg_we,
  input  wire logic [0:0]         cfg_index,
  input  wire logic [0:0]         cfg_wdata,
  input  wire logic               in_cmd,
  input  wire logic [LINE_W-1:0]  in_line,
  input  wire logic               in_level,
  input  wire logic [STAMP_W-1:0] in_event_time,
  input  wire logic [STAMP_W-1:0] in_now_time,
  input  wire logic               in_global_enable,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    out_interrupt_request,
  output logic [63:0]             out_line_bits,
  output logic                    out_queue_overflow,
  output logic [4:0]              out_pending_left
);

  localparam int IDX_W  = $clog2(QUEUE_DEPTH);
  localparam int SUM_W  = IDX_W + 1;
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int WIDE_W = (CNT_W > 5) ? CNT_W : 5;

  // ring address: head plus logical slot, one wrap at most
  function automatic logic [IDX_W-1:0] ring_addr(input logic [IDX_W-1:0] head,
                                                 input logic [IDX_W-1:0] slot);
    logic [SUM_W-1:0] s;
    s = {1'b0, head} + {1'b0, slot};
    if (s >= SUM_W'(QUEUE_DEPTH)) s = s - SUM_W'(QUEUE_DEPTH);
    return s[IDX_W-1:0];
  endfunction

  tilq_entry_t mem [QUEUE_DEPTH];
  tilq_entry_t rdata_r;

  logic                  trigger_mode_r, clear_on_low_r;
  logic [IDX_W-1:0]      head_r, head_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [IDX_W-1:0]      j_r, j_nxt;
  logic [LINE_COUNT-1:0] line_vec_r, line_vec_nxt;
  logic [LINE_COUNT-1:0] raised_r, raised_nxt;
  logic                  permit_r, permit_nxt;
  logic                  ovf_r, ovf_nxt;

  logic                  cmd_r, level_r, gen_r;
  logic [LINE_W-1:0]     line_r;
  logic [STAMP_W-1:0]    evt_r, now_r;

  logic                  out_valid_r;
  logic                  irq_r, ovf_out_r;
  logic [63:0]           bits_r;
  logic [4:0]            left_r;

  logic                  mem_we, mem_re;
  logic [IDX_W-1:0]      waddr, raddr;
  tilq_entry_t           wdata, new_entry;

  logic                  in_range, grants;
  logic [LINE_COUNT-1:0] bit_mask;
  logic [WIDE_W-1:0]     cnt_ext;

  assign new_entry = '{stamp: evt_r, line: line_r, level: level_r};

  // decoded line of the entry at the head of the queue
  assign in_range = ({1'b0, rdata_r.line} < (LINE_W + 1)'(LINE_COUNT));
  assign bit_mask = in_range ? (LINE_COUNT'(1) << rdata_r.line) : '0;
  assign grants   = (trigger_mode_r == MODE_EDGE) && rdata_r.level &&
                    (bit_mask != '0) && ((raised_r & bit_mask) == '0);

  assign status.is_tick  = (cmd_r == CMD_TICK);
  assign status.full     = (count_r == CNT_W'(QUEUE_DEPTH));
  assign status.empty    = (count_r == '0);
  assign status.j_zero   = (j_r == '0);
  assign status.later    = (rdata_r.stamp > evt_r);
  assign status.due      = (rdata_r.stamp <= now_r);
  assign status.stop     = (trigger_mode_r == MODE_LEVEL) || permit_r || grants;
  assign status.out_busy = out_valid_r && out_stall;

  always_comb begin
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    waddr        = ring_addr(head_r, j_r + IDX_W'(1));
    raddr        = head_r;
    wdata        = new_entry;
    head_nxt     = head_r;
    count_nxt    = count_r;
    j_nxt        = j_r;
    line_vec_nxt = line_vec_r;
    raised_nxt   = raised_r;
    permit_nxt   = permit_r;
    ovf_nxt      = ovf_r;
    unique case (op)
      OP_NONE, OP_PUBLISH: ;
      OP_CAPTURE:  ovf_nxt = 1'b0;
      OP_OVERFLOW: ovf_nxt = 1'b1;
      OP_PUT_FRONT: begin
        mem_we    = 1'b1;
        waddr     = head_r;
        count_nxt = count_r + CNT_W'(1);
      end
      OP_SCAN_START: begin
        mem_re = 1'b1;
        j_nxt  = IDX_W'(count_r - CNT_W'(1));
        raddr  = ring_addr(head_r, j_nxt);
      end
      OP_SHIFT: begin
        mem_we = 1'b1;
        wdata  = rdata_r;
        mem_re = 1'b1;
        j_nxt  = j_r - IDX_W'(1);
        raddr  = ring_addr(head_r, j_nxt);
      end
      OP_PLACE: begin
        mem_we    = 1'b1;
        count_nxt = count_r + CNT_W'(1);
      end
      OP_TICK_INIT: permit_nxt = (trigger_mode_r == MODE_LEVEL);
      OP_TICK_READ: mem_re = 1'b1;
      OP_TICK_APPLY: begin
        if (trigger_mode_r == MODE_EDGE) begin
          if (rdata_r.level) begin
            raised_nxt   = raised_r | bit_mask;
            line_vec_nxt = line_vec_r | bit_mask;
          end else begin
            raised_nxt   = raised_r & ~bit_mask;
            line_vec_nxt = line_vec_r & ~bit_mask;
          end
        end else begin
          priority if (rdata_r.level) line_vec_nxt = line_vec_r | bit_mask;
          else if (clear_on_low_r) line_vec_nxt = line_vec_r & ~bit_mask;
          else line_vec_nxt = line_vec_r;
        end
        permit_nxt = permit_r | grants;
        head_nxt   = (head_r == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + IDX_W'(1);
        count_nxt  = count_r - CNT_W'(1);
      end
      default: ;
    endcase
  end

  // event store
  always_ff @(posedge clk) begin
    if (mem_we) mem[waddr] <= wdata;
    if (mem_re) rdata_r <= mem[raddr];
  end

  // control and line state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trigger_mode_r <= MODE_LEVEL;
      clear_on_low_r <= 1'b0;
      head_r         <= '0;
      count_r        <= '0;
      line_vec_r     <= '0;
      raised_r       <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_TRIGGER_MODE: trigger_mode_r <= cfg_wdata[0];
          CFG_CLEAR_ON_LOW: clear_on_low_r <= cfg_wdata[0];
          default: ;
        endcase
      end
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      line_vec_r  <= line_vec_nxt;
      raised_r    <= raised_nxt;
      out_valid_r <= (op == OP_PUBLISH) || (out_valid_r && out_stall);
    end
  end

  assign cnt_ext = WIDE_W'(count_r);

  // working and result registers
  always_ff @(posedge clk) begin
    j_r      <= j_nxt;
    permit_r <= permit_nxt;
    ovf_r    <= ovf_nxt;
    if (op == OP_CAPTURE) begin
      cmd_r   <= in_cmd;
      line_r  <= in_line;
      level_r <= in_level;
      evt_r   <= in_event_time;
      now_r   <= in_now_time;
      gen_r   <= in_global_enable;
    end
    if (op == OP_PUBLISH) begin
      irq_r     <= (cmd_r == CMD_TICK) && permit_r && (line_vec_r != '0) && gen_r;
      bits_r    <= 64'(line_vec_r);
      ovf_out_r <= ovf_r;
      left_r    <= cnt_ext[4:0];
    end
  end

  assign out_valid             = out_valid_r;
  assign out_interrupt_request = irq_r;
  assign out_line_bits         = bits_r;
  assign out_queue_overflow    = ovf_out_r;
  assign out_pending_left      = left_r;

endmodule

`default_nettype wire
